### hw/rtl/l2h_pkg.sv
// ============================================================================
// l2h_pkg
// Shared types, constants and the mix round for the lookup2 byte hash unit.
// ============================================================================
package l2h_pkg;

    localparam logic [31:0] GOLDEN_RATIO = 32'h9e3779b9;
    localparam int          BLOCK_BYTES  = 12;
    localparam int          FILL_W       = 4;
    localparam int          MIX_LINES    = 9;
    localparam int          STEP_W       = 4;
    localparam logic [STEP_W-1:0] LAST_LINE = STEP_W'(MIX_LINES - 1);

    typedef enum logic [1:0] {
        CMD_BLOCK,
        CMD_FINAL,
        CMD_BLOCK_FINAL
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic        start;
        logic [31:0] seed;
        logic [31:0] wa;
        logic [31:0] wb;
        logic [31:0] wc;
        logic [31:0] len;
    } cmd_t;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
    } abc_t;

    function automatic abc_t mix_line(input logic [STEP_W-1:0] line, input abc_t s);
        abc_t r;
        r = s;
        case (line)
            4'd0: r.a = (s.a - s.b - s.c) ^ (s.c >> 13);
            4'd1: r.b = (s.b - s.c - s.a) ^ (s.a << 8);
            4'd2: r.c = (s.c - s.a - s.b) ^ (s.b >> 13);
            4'd3: r.a = (s.a - s.b - s.c) ^ (s.c >> 12);
            4'd4: r.b = (s.b - s.c - s.a) ^ (s.a << 16);
            4'd5: r.c = (s.c - s.a - s.b) ^ (s.b >> 5);
            4'd6: r.a = (s.a - s.b - s.c) ^ (s.c >> 3);
            4'd7: r.b = (s.b - s.c - s.a) ^ (s.a << 10);
            4'd8: r.c = (s.c - s.a - s.b) ^ (s.b >> 15);
            default: r = s;
        endcase
        return r;
    endfunction

endpackage

### hw/rtl/l2h_if.sv
// ============================================================================
// l2h_if
// Valid/ready channels of the lookup2 byte hash unit: key bytes, hash, seed.
// ============================================================================
interface l2h_key_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;

    modport source (output valid, output data_byte, output has_byte, output last,
                    input ready);
    modport sink   (input valid, input data_byte, input has_byte, input last,
                    output ready);
endinterface

interface l2h_hash_if;
    logic        valid;
    logic        ready;
    logic [31:0] hash;

    modport source (output valid, output hash, input ready);
    modport sink   (input valid, input hash, output ready);
endinterface

interface l2h_seed_if;
    logic        valid;
    logic        ready;
    logic [31:0] seed;

    modport source (output valid, output seed, input ready);
    modport sink   (input valid, input seed, output ready);
endinterface

### hw/rtl/lookup2_byte_hash_unit.sv
// Flow: a last item's command is queued, added into a/b/c, run through the mix
//   lines and registered as the hash; if that item also completes a 12-byte block,
//   the block is mixed first, then the length is added and mixed again.
// Throughput: one byte per cycle while the command queue is not full; the mixer
//   runs one add and nine mix lines per block or key end, one at a time.
// Reset: rst_n asynchronous, active low; no key open, seed cleared to 0.
// ============================================================================
// lookup2_byte_hash_unit
// Streaming 32-bit lookup2 hash over a key given one byte per request.
// ============================================================================
module lookup2_byte_hash_unit
    import l2h_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    l2h_seed_if.sink    cfg,
    l2h_key_if.sink     key_in,
    l2h_hash_if.source  hash_out
);

    logic [31:0] seed_reg;
    logic        q_push;
    logic        q_pop;
    logic        q_full;
    logic        q_empty;
    cmd_t        q_in;
    cmd_t        q_out;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= '0;
        end
        else if (cfg.valid)
        begin
            seed_reg <= cfg.seed;
        end
    end

    l2h_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .key_in (key_in),
        .seed   (seed_reg),
        .q_full (q_full),
        .q_push (q_push),
        .q_cmd  (q_in)
    );

    l2h_cmd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .empty     (q_empty)
    );

    l2h_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_cmd    (q_out),
        .q_pop    (q_pop),
        .hash_out (hash_out)
    );

endmodule

### hw/rtl/l2h_front.sv
// ============================================================================
// l2h_front
// Takes key bytes, packs 12-byte blocks and tails, issues mix commands.
// ============================================================================
module l2h_front
    import l2h_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    l2h_key_if.sink     key_in,
    input  logic [31:0] seed,
    input  logic        q_full,
    output logic        q_push,
    output cmd_t        q_cmd
);

    logic                                in_key_reg;
    logic                                first_pending_reg;
    logic [31:0]                         key_seed_reg;
    logic [FILL_W-1:0]                   fill_reg;
    logic [31:0]                         len_reg;
    logic [BLOCK_BYTES-1:0][7:0]         blk_reg;

    logic                                act;
    logic                                start_now;
    logic [FILL_W-1:0]                   fill_cur;
    logic [FILL_W-1:0]                   fill_after;
    logic [31:0]                         len_cur;
    logic [31:0]                         len_after;
    logic [BLOCK_BYTES-1:0][7:0]         blk_next;
    logic                                blk_full;
    logic                                first_cmd;

    assign key_in.ready = !q_full;
    assign act = key_in.valid && key_in.ready && (key_in.has_byte || key_in.last);
    assign start_now = !in_key_reg;
    assign first_cmd = start_now || first_pending_reg;

    always_comb
    begin
        fill_cur = start_now ? '0 : fill_reg;
        len_cur  = start_now ? '0 : len_reg;
        blk_next = (fill_cur == '0) ? '0 : blk_reg;
        if (key_in.has_byte)
        begin
            blk_next[fill_cur] = key_in.data_byte;
        end
        blk_full   = key_in.has_byte && (fill_cur == FILL_W'(BLOCK_BYTES - 1));
        fill_after = blk_full ? '0 : fill_cur + {{(FILL_W-1){1'b0}}, key_in.has_byte};
        len_after  = len_cur + {31'd0, key_in.has_byte};
    end

    always_comb
    begin
        q_push      = act && (blk_full || key_in.last);
        q_cmd.start = first_cmd;
        q_cmd.seed  = start_now ? seed : key_seed_reg;
        q_cmd.len   = key_in.last ? len_after : '0;
        if (blk_full)
        begin
            q_cmd.kind = key_in.last ? CMD_BLOCK_FINAL : CMD_BLOCK;
            q_cmd.wa   = blk_next[3:0];
            q_cmd.wb   = blk_next[7:4];
            q_cmd.wc   = blk_next[11:8];
        end
        else
        begin
            q_cmd.kind = CMD_FINAL;
            if (fill_after == '0)
            begin
                q_cmd.wa = '0;
                q_cmd.wb = '0;
                q_cmd.wc = '0;
            end
            else
            begin
                q_cmd.wa = blk_next[3:0];
                q_cmd.wb = blk_next[7:4];
                q_cmd.wc = {blk_next[10:8], 8'h00};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_key_reg        <= 1'b0;
            first_pending_reg <= 1'b0;
            key_seed_reg      <= '0;
            fill_reg          <= '0;
            len_reg           <= '0;
            blk_reg           <= '0;
        end
        else if (act)
        begin
            if (key_in.has_byte)
            begin
                blk_reg <= blk_next;
            end
            if (key_in.last)
            begin
                in_key_reg        <= 1'b0;
                first_pending_reg <= 1'b0;
                fill_reg          <= '0;
                len_reg           <= '0;
            end
            else
            begin
                in_key_reg        <= 1'b1;
                first_pending_reg <= first_cmd && !q_push;
                fill_reg          <= fill_after;
                len_reg           <= len_after;
                if (start_now)
                begin
                    key_seed_reg <= seed;
                end
            end
        end
    end

endmodule

### hw/rtl/l2h_cmd_queue.sv
// ============================================================================
// l2h_cmd_queue
// Short command queue between the byte front end and the mixer.
// ============================================================================
module l2h_cmd_queue
    import l2h_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_data,
    output logic full,
    input  logic pop,
    output cmd_t pop_data,
    output logic empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    cmd_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == CNT_FULL);
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

### hw/rtl/l2h_back.sv
// ============================================================================
// l2h_back
// Mixer: adds words into a/b/c, runs the mix one line per cycle (a key's last
// line waits for a free hash output) and holds the finished hash in a register.
// ============================================================================
module l2h_back
    import l2h_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_empty,
    input  cmd_t        q_cmd,
    output logic        q_pop,
    l2h_hash_if.source  hash_out
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MIX,
        ST_TAIL
    } state_t;

    state_t            state_reg;
    logic [STEP_W-1:0] step_reg;
    abc_t              abc_reg;
    cmd_kind_t         kind_reg;
    logic [31:0]       len_reg;
    logic              out_valid_reg;
    logic [31:0]       out_hash_reg;

    abc_t              base;
    abc_t              loaded;
    abc_t              mixed;
    logic              line_done;
    logic              out_free;
    logic              hold;
    logic              hash_done;
    logic              out_valid_next;

    assign hash_out.valid = out_valid_reg;
    assign hash_out.hash  = out_hash_reg;

    assign q_pop     = (state_reg == ST_IDLE) && !q_empty;
    assign line_done = (step_reg == LAST_LINE);
    assign out_free  = !out_valid_reg || hash_out.ready;
    assign hold      = line_done && (kind_reg == CMD_FINAL) && !out_free;
    assign mixed     = mix_line(step_reg, abc_reg);

    assign hash_done      = (state_reg == ST_MIX) && line_done && (kind_reg == CMD_FINAL)
                            && !hold;
    assign out_valid_next = hash_done || (out_valid_reg && !hash_out.ready);

    always_comb
    begin
        if (q_cmd.start)
        begin
            base.a = GOLDEN_RATIO;
            base.b = GOLDEN_RATIO;
            base.c = q_cmd.seed;
        end
        else
        begin
            base = abc_reg;
        end
        loaded.a = base.a + q_cmd.wa;
        loaded.b = base.b + q_cmd.wb;
        loaded.c = base.c + q_cmd.wc + ((q_cmd.kind == CMD_FINAL) ? q_cmd.len : 32'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            abc_reg       <= '0;
            kind_reg      <= CMD_BLOCK;
            len_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_hash_reg  <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (!q_empty)
                    begin
                        abc_reg   <= loaded;
                        kind_reg  <= q_cmd.kind;
                        len_reg   <= q_cmd.len;
                        step_reg  <= '0;
                        state_reg <= ST_MIX;
                    end
                end
                ST_MIX:
                begin
                    if (!hold)
                    begin
                        abc_reg <= mixed;
                        if (!line_done)
                        begin
                            step_reg <= step_reg + 1'b1;
                        end
                        else
                        begin
                            unique case (kind_reg)
                                CMD_BLOCK:
                                begin
                                    state_reg <= ST_IDLE;
                                end
                                CMD_FINAL:
                                begin
                                    out_hash_reg  <= mixed.c;
                                    state_reg     <= ST_IDLE;
                                end
                                CMD_BLOCK_FINAL:
                                begin
                                    state_reg <= ST_TAIL;
                                end
                                default:
                                begin
                                    state_reg <= ST_IDLE;
                                end
                            endcase
                        end
                    end
                end
                ST_TAIL:
                begin
                    abc_reg.c <= abc_reg.c + len_reg;
                    kind_reg  <= CMD_FINAL;
                    step_reg  <= '0;
                    state_reg <= ST_MIX;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
